// ===== rtl/core/thb_pkg.sv =====
// Shared types, widths and constants of the temperature band hours histogram.
package thb_pkg;

    localparam int NUM_BANDS   = 10;
    localparam int COUNT_WIDTH = 32;

    localparam int OP_W       = 2;
    localparam int TEMP_W     = 18;
    localparam int SEL_W      = 4;
    localparam int BAND_W     = 4;
    localparam int TOTAL_W    = 32;
    localparam int WIN_W      = 8;
    localparam int EDGE_W     = 18;
    localparam int BW_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // running sum of up to 255 samples of 18 bits
    localparam int SUM_W  = TEMP_W + WIN_W + 1;
    // first edge times window length, and band width times window length
    localparam int BASE_W = EDGE_W + WIN_W + 1;
    localparam int STEP_W = BW_W + WIN_W;
    // scaled band edges: base plus up to NUM_BANDS-2 steps
    localparam int THR_W  = BASE_W + $clog2(NUM_BANDS) + 1;

    localparam int WIN_RESET_I  = 10;
    localparam int EDGE_RESET_I = -10000;
    localparam int BW_RESET_I   = 10000;

    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(WIN_RESET_I);
    localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(EDGE_RESET_I);
    localparam logic [BW_W-1:0]   BW_RESET   = BW_W'(BW_RESET_I);
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(EDGE_RESET_I * WIN_RESET_I);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(BW_RESET_I * WIN_RESET_I);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_EDGE   = 2'd1,
        CFG_WIDTH  = 2'd2
    } cfg_idx_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WIN_W-1:0]  weff;      // window length, zero taken as one
        logic [BASE_W-1:0] base_thr;  // first edge * weff, signed
        logic [STEP_W-1:0] step_thr;  // band width * weff
    } thb_cfg_t;

    // counter bank control for one transfer
    typedef struct packed {
        logic                 inc;
        logic                 clr;
        logic [NUM_BANDS-1:0] hit;
    } thb_cnt_ctl_t;

endpackage

// ===== rtl/core/thb_cfg.sv =====
// Configuration registers with the scaled edge base and step kept alongside.
module thb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [thb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [thb_pkg::CFG_DATA_W-1:0] cfg_data,
    output thb_pkg::thb_cfg_t           cfg
);
    import thb_pkg::*;

    logic [WIN_W-1:0]  weff_reg, weff_next;
    logic [EDGE_W-1:0] first_reg, first_next;
    logic [BW_W-1:0]   width_reg, width_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        weff_next  = weff_reg;
        first_next = first_reg;
        width_next = width_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW:
                begin
                    if (cfg_data[WIN_W-1:0] == '0)
                        weff_next = WIN_W'(1);
                    else
                        weff_next = cfg_data[WIN_W-1:0];
                end
                CFG_EDGE:  first_next = cfg_data[EDGE_W-1:0];
                CFG_WIDTH: width_next = cfg_data[BW_W-1:0];
                default:   ;
            endcase
        end
    end

    // scaled values follow the new settings into the same edge
    assign base_next = BASE_W'($signed(first_next) * $signed({1'b0, weff_next}));
    assign step_next = STEP_W'(width_next * weff_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weff_reg  <= WIN_RESET;
            first_reg <= EDGE_RESET;
            width_reg <= BW_RESET;
            base_reg  <= BASE_RESET;
            step_reg  <= STEP_RESET;
        end
        else
        begin
            weff_reg  <= weff_next;
            first_reg <= first_next;
            width_reg <= width_next;
            base_reg  <= base_next;
            step_reg  <= step_next;
        end
    end

    assign cfg.weff     = weff_reg;
    assign cfg.base_thr = base_reg;
    assign cfg.step_thr = step_reg;

endmodule

// ===== rtl/core/thb_band.sv =====
// Band selection: window sum against every scaled band edge in parallel.
module thb_band (
    input  thb_pkg::thb_cfg_t                   cfg,
    input  logic signed [thb_pkg::SUM_W-1:0]    sum,
    output logic [thb_pkg::BAND_W-1:0]          band,
    output logic [thb_pkg::NUM_BANDS-1:0]       hit
);
    import thb_pkg::*;

    logic [NUM_BANDS-2:0]     below;
    logic signed [THR_W-1:0]  sum_ext;

    assign sum_ext = THR_W'(sum);

    for (genvar k = 0; k < NUM_BANDS - 1; k++)
    begin : g_edge
        logic signed [THR_W-1:0] thr;
        assign thr = THR_W'($signed(cfg.base_thr)) + THR_W'(cfg.step_thr) * THR_W'(k);
        assign below[k] = sum_ext < thr;
    end

    // lowest edge that the sum lies below wins; open top band otherwise
    always_comb
    begin
        band = BAND_W'(NUM_BANDS - 1);
        for (int k = NUM_BANDS - 2; k >= 0; k--)
        begin
            if (below[k])
                band = BAND_W'(k);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BANDS; i++)
            hit[i] = (band == BAND_W'(i));
    end

endmodule

// ===== rtl/core/thb_counters.sv =====
// Bank of saturating band minute counters, one lane per band.
module thb_counters (
    input  logic                              clk,
    input  logic                              rst_n,
    input  thb_pkg::thb_cnt_ctl_t             ctl,
    input  logic [thb_pkg::WIN_W-1:0]         weff,
    input  logic [thb_pkg::NUM_BANDS-1:0]     rd_hot,
    output logic [thb_pkg::COUNT_WIDTH-1:0]   upd_total,
    output logic [thb_pkg::COUNT_WIDTH-1:0]   rd_total
);
    import thb_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg [NUM_BANDS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_BANDS];
    logic [COUNT_WIDTH-1:0] bumped [NUM_BANDS];

    for (genvar i = 0; i < NUM_BANDS; i++)
    begin : g_lane
        logic [COUNT_WIDTH:0] wide;
        assign wide = {1'b0, count_reg[i]} + (COUNT_WIDTH + 1)'(weff);
        // carry out means the counter would pass its top value
        assign bumped[i] = wide[COUNT_WIDTH] ? '1 : wide[COUNT_WIDTH-1:0];

        always_comb
        begin
            if (ctl.clr)
                count_next[i] = '0;
            else if (ctl.inc && ctl.hit[i])
                count_next[i] = bumped[i];
            else
                count_next[i] = count_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                count_reg[i] <= '0;
            else
                count_reg[i] <= count_next[i];
        end
    end

    always_comb
    begin
        upd_total = '0;
        rd_total  = '0;
        for (int i = 0; i < NUM_BANDS; i++)
        begin
            if (ctl.hit[i])
                upd_total = upd_total | bumped[i];
            if (rd_hot[i])
                rd_total = rd_total | count_reg[i];
        end
    end

endmodule

// ===== rtl/core/temperature_band_hours_histogram_top.sv =====
// Top level of the temperature band hours histogram.
//
// Each transfer on the sample channel carries one operation and produces
// exactly one transfer on the result channel, in the following cycle at the
// earliest. A new transfer is taken every cycle: all work is done in the
// logic between the input ports and the result register, and the sample
// channel stalls only while a finished result is held by a stalled result
// channel. Sample operations add temp_milli to a running window sum; when
// the window_samples-th sample arrives the mean is binned by comparing the
// sum against each band edge scaled by the window length (no divide), and
// the window length in minutes is added to that band's saturating counter.
// Read returns one counter, clear zeroes all counters and the window.
// The scaled edge base and step are recomputed on each configuration
// write, which is only legal while the block is idle. Counters clear at
// reset; no clearing pass is needed.
module temperature_band_hours_histogram_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [thb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [thb_pkg::OP_W-1:0]          operation,
    input  logic signed [thb_pkg::TEMP_W-1:0] temp_milli,
    input  logic [thb_pkg::SEL_W-1:0]         band_select,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              window_done,
    output logic [thb_pkg::BAND_W-1:0]        band_index,
    output logic [thb_pkg::TOTAL_W-1:0]       band_total
);
    import thb_pkg::*;

    thb_cfg_t               cfg;
    thb_cnt_ctl_t           cnt_ctl;

    logic                   accept;
    logic [WIN_W-1:0]       fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] sum_new;
    logic [WIN_W:0]         fill_inc;
    logic                   closes;

    logic [BAND_W-1:0]      band;
    logic [NUM_BANDS-1:0]   hit;
    logic [NUM_BANDS-1:0]   rd_hot;
    logic [COUNT_WIDTH-1:0] upd_total;
    logic [COUNT_WIDTH-1:0] rd_total;

    logic                   valid_reg, valid_next;
    logic                   done_reg, done_next;
    logic [BAND_W-1:0]      index_reg, index_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;

    thb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // hold the sample channel only while a result waits on a stalled sink
    assign sample_stall = valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;

    // window bookkeeping for this sample
    assign sum_new  = sum_reg + SUM_W'(temp_milli);
    assign fill_inc = {1'b0, fill_reg} + (WIN_W + 1)'(1);
    assign closes   = fill_inc >= {1'b0, cfg.weff};

    thb_band u_band (
        .cfg  (cfg),
        .sum  (sum_new),
        .band (band),
        .hit  (hit)
    );

    // read select, empty for a band beyond the last one
    always_comb
    begin
        for (int i = 0; i < NUM_BANDS; i++)
            rd_hot[i] = (band_select == SEL_W'(i));
    end

    always_comb
    begin
        cnt_ctl.inc = accept && (op_t'(operation) == OP_SAMPLE) && closes;
        cnt_ctl.clr = accept && (op_t'(operation) == OP_CLEAR);
        cnt_ctl.hit = hit;
    end

    thb_counters u_counters (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cnt_ctl),
        .weff      (cfg.weff),
        .rd_hot    (rd_hot),
        .upd_total (upd_total),
        .rd_total  (rd_total)
    );

    // window state and result payload
    always_comb
    begin
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        done_next  = done_reg;
        index_next = index_reg;
        total_next = total_reg;
        if (accept)
        begin
            done_next  = 1'b0;
            index_next = '0;
            total_next = '0;
            case (op_t'(operation))
                OP_SAMPLE:
                begin
                    if (closes)
                    begin
                        fill_next  = '0;
                        sum_next   = '0;
                        done_next  = 1'b1;
                        index_next = band;
                        total_next = TOTAL_W'(upd_total);
                    end
                    else
                    begin
                        fill_next = fill_inc[WIN_W-1:0];
                        sum_next  = sum_new;
                    end
                end
                OP_READ:
                begin
                    index_next = band_select;
                    total_next = TOTAL_W'(rd_total);
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                    sum_next  = '0;
                end
                default: ;
            endcase
        end
    end

    // result register: loads on each accepted transfer, drains when taken
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (result_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg  <= done_next;
        index_reg <= index_next;
        total_reg <= total_next;
    end

    assign result_valid = valid_reg;
    assign window_done  = done_reg;
    assign band_index   = index_reg;
    assign band_total   = total_reg;

endmodule
